// ===== rtl/pwc_pkg.sv =====
// pwc_pkg: shared types and constants for the pulse-width capture block
// used by the lane, merge stage, interfaces and top level; no dependencies
`default_nettype none

package pwc_pkg;

  localparam int unsigned NUM_CH    = 6;
  localparam int unsigned TS_W      = 32;
  localparam logic [TS_W-1:0] TIMEOUT_RESET = 32'd200000;

  // event kind carried by each input word
  typedef enum logic {
    ACT_EDGE  = 1'b0,
    ACT_CHECK = 1'b1
  } action_t;

  typedef logic [TS_W-1:0]   tick_t;
  typedef logic [NUM_CH-1:0] chmask_t;

  // per-word control broadcast from the top level to every lane
  typedef struct packed {
    logic  load;        // word accepted this cycle
    logic  is_check;    // connection check rather than pin edges
    logic  check_clear; // armed check: clear all widths
    tick_t timestamp;
    tick_t timeout;
  } lane_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/pwc_in_if.sv =====
// pwc_in_if: input channel carrying edge and check events
// depends on pwc_pkg for field types
`default_nettype none

interface pwc_in_if;
  import pwc_pkg::*;

  logic    valid;
  logic    ready;
  logic    action;
  chmask_t rise_mask;
  chmask_t fall_mask;
  tick_t   timestamp;

  modport source (output valid, action, rise_mask, fall_mask, timestamp, input ready);
  modport sink   (input valid, action, rise_mask, fall_mask, timestamp, output ready);
endinterface

`default_nettype wire

// ===== rtl/pwc_out_if.sv =====
// pwc_out_if: result channel carrying the six channel widths
// depends on pwc_pkg for field types
`default_nettype none

interface pwc_out_if;
  import pwc_pkg::*;

  logic  valid;
  logic  ready;
  tick_t width_ch0;
  tick_t width_ch1;
  tick_t width_ch2;
  tick_t width_ch3;
  tick_t width_ch4;
  tick_t width_ch5;

  modport source (output valid, width_ch0, width_ch1, width_ch2, width_ch3, width_ch4,
                  width_ch5, input ready);
  modport sink   (input valid, width_ch0, width_ch1, width_ch2, width_ch3, width_ch4,
                  width_ch5, output ready);
endinterface

`default_nettype wire

// ===== rtl/pwc_lane.sv =====
// pwc_lane: capture state and width update for one channel
// depends on pwc_pkg; one instance per channel in the top level
`default_nettype none

module pwc_lane (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire pwc_pkg::lane_ctrl_t ctrl,
  input  wire logic               rise,
  input  wire logic               fall,
  output pwc_pkg::tick_t          width_nxt
);
  import pwc_pkg::*;

  tick_t rise_r, rise_nxt;
  tick_t fall_r, fall_nxt;
  tick_t width_r;
  tick_t since_fall;

  assign since_fall = ctrl.timestamp - fall_r;

  // check words first; otherwise rising edge wins, then falling edge, then timeout
  always_comb begin
    rise_nxt  = rise_r;
    fall_nxt  = fall_r;
    width_nxt = width_r;
    if (ctrl.load) begin
      if (ctrl.is_check) begin
        if (ctrl.check_clear) begin
          width_nxt = '0;
        end
      end else if (rise) begin
        rise_nxt = ctrl.timestamp;
      end else if (fall) begin
        width_nxt = ctrl.timestamp - rise_r;
        fall_nxt  = ctrl.timestamp;
      end else if (since_fall > ctrl.timeout) begin
        width_nxt = '0;
      end
    end
  end

  // channel state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rise_r  <= '0;
      fall_r  <= '0;
      width_r <= '0;
    end else begin
      rise_r  <= rise_nxt;
      fall_r  <= fall_nxt;
      width_r <= width_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pwc_merge.sv =====
// pwc_merge: gathers the lane widths into the registered result word
// depends on pwc_pkg and pwc_out_if
`default_nettype none

module pwc_merge (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          load,
  input  wire pwc_pkg::tick_t widths [pwc_pkg::NUM_CH],
  output logic               free,
  pwc_out_if.source          out_if
);
  import pwc_pkg::*;

  logic  valid_r;
  tick_t width_r [NUM_CH];

  // room for a new word when empty or the held word leaves now
  assign free = !valid_r || out_if.ready;

  // result valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_if.ready) begin
      valid_r <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (load) begin
      width_r <= widths;
    end
  end

  assign out_if.valid     = valid_r;
  assign out_if.width_ch0 = width_r[0];
  assign out_if.width_ch1 = width_r[1];
  assign out_if.width_ch2 = width_r[2];
  assign out_if.width_ch3 = width_r[3];
  assign out_if.width_ch4 = width_r[4];
  assign out_if.width_ch5 = width_r[5];

endmodule

`default_nettype wire

// ===== rtl/multi_channel_pulse_width_capture_top.sv =====
// multi_channel_pulse_width_capture_top: six-channel pulse-width capture
// depends on pwc_pkg, pwc_in_if, pwc_out_if, pwc_lane and pwc_merge
//
// Usage: each input word is either a pin edge event (rise and fall masks
// plus a 32-bit timestamp) or a connection check. Every accepted word gives
// exactly one result word holding the six channel widths after the update.
// The six channels are handled by parallel lanes in the accept cycle and the
// merge stage registers their widths, so a result appears in the cycle after its
// input word is accepted. One word per cycle is taken as long as the result
// register is empty or its word is taken in the same cycle; the subtract and
// compare in each lane are combinational and allow that rate.
// When the receiver stalls, the result is held and in_if.ready falls until it
// is taken. cfg_we with cfg_wdata loads the timeout in ticks; write it only
// while no result is pending. Reset sets all rise times, fall times and
// widths to zero, disarms the check and loads a timeout of 200000 ticks.
`default_nettype none

module multi_channel_pulse_width_capture_top (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           cfg_we,
  input  wire pwc_pkg::tick_t cfg_wdata,
  pwc_in_if.sink              in_if,
  pwc_out_if.source           out_if
);
  import pwc_pkg::*;

  tick_t      timeout_r;
  logic       armed_r, armed_nxt;
  logic       accept;
  logic       free;
  lane_ctrl_t ctrl;
  tick_t      widths [NUM_CH];

  assign in_if.ready = free;
  assign accept      = in_if.valid && free;

  // timeout register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      timeout_r <= cfg_wdata;
    end
  end

  // connection check: arm on first check, any edge word disarms
  always_comb begin
    armed_nxt = armed_r;
    if (accept) begin
      armed_nxt = (action_t'(in_if.action) == ACT_CHECK);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r <= 1'b0;
    end else begin
      armed_r <= armed_nxt;
    end
  end

  // control broadcast to the lanes
  always_comb begin
    ctrl.load        = accept;
    ctrl.is_check    = (action_t'(in_if.action) == ACT_CHECK);
    ctrl.check_clear = armed_r;
    ctrl.timestamp   = in_if.timestamp;
    ctrl.timeout     = timeout_r;
  end

  // one lane per channel
  for (genvar c = 0; c < NUM_CH; c++) begin : g_lane
    pwc_lane u_lane (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .rise      (in_if.rise_mask[c]),
      .fall      (in_if.fall_mask[c]),
      .width_nxt (widths[c])
    );
  end

  // result register
  pwc_merge u_merge (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (accept),
    .widths (widths),
    .free   (free),
    .out_if (out_if)
  );

endmodule

`default_nettype wire
